>>> rtl/best_fit_block_allocator_defines.svh
// -----------------------------------------------------------------------------
// best_fit_block_allocator_defines.svh
// Assertion macros for the allocator top module. They expect clk and arst_n in
// scope and compile to nothing when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BFBA_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BFBA_ASSERT(lbl, ante, cons, msg)
`define BFBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/bfba_pkg.sv
// -----------------------------------------------------------------------------
// bfba_pkg
// Shared widths, defaults and codes of the best-fit block allocator.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfba_pkg;

	localparam int HEAP_BLOCKS_DEF = 64;
	localparam int BLOCK_BYTES_DEF = 16;

	localparam int BYTES_W  = 11;
	localparam int START_W  = 6;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 6;
	localparam int BLOCKS_W = 7;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 2'd0,
		ST_NO_SPACE     = 2'd1,
		ST_ALREADY_FREE = 2'd2,
		ST_NOT_START    = 2'd3
	} status_t;

endpackage

`default_nettype wire

>>> rtl/bfba_req_if.sv
// -----------------------------------------------------------------------------
// bfba_req_if
// Request channel: allocate or free word with valid/ready handshake.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfba_req_if;
	logic                          valid;
	logic                          ready;
	bfba_pkg::op_t                 operation;
	logic [bfba_pkg::BYTES_W-1:0]  request_bytes;
	logic [bfba_pkg::START_W-1:0]  run_start;

	modport source (output valid, operation, request_bytes, run_start, input ready);
	modport sink   (input valid, operation, request_bytes, run_start, output ready);
endinterface

`default_nettype wire

>>> rtl/bfba_rsp_if.sv
// -----------------------------------------------------------------------------
// bfba_rsp_if
// Response channel: status and granted run, valid/ready handshake.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfba_rsp_if;
	logic                          valid;
	logic                          ready;
	bfba_pkg::status_t             status;
	logic [bfba_pkg::INDEX_W-1:0]  granted_index;
	logic [bfba_pkg::BLOCKS_W-1:0] granted_blocks;

	modport source (output valid, status, granted_index, granted_blocks, input ready);
	modport sink   (input valid, status, granted_index, granted_blocks, output ready);
endinterface

`default_nettype wire

>>> rtl/bfba_hdr_mem.sv
// -----------------------------------------------------------------------------
// bfba_hdr_mem
// Run header table: one {free, length} entry per block index.
// One write port, one read port, registered read data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfba_hdr_mem #(
	parameter  int DEPTH = bfba_pkg::HEAP_BLOCKS_DEF,
	localparam int AW    = $clog2(DEPTH),
	localparam int DW    = $clog2(DEPTH + 1) + 1
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/bfba_size_div.sv
// -----------------------------------------------------------------------------
// bfba_size_div
// Bytes to blocks: ceiling division by the block size through a reciprocal
// multiply, with a floor of one block.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfba_size_div #(
	parameter  int DIVISOR = bfba_pkg::BLOCK_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [bfba_pkg::BYTES_W-1:0] bytes,
	output logic                              done,
	output logic      [bfba_pkg::BYTES_W-1:0] need
);

	localparam int BW    = bfba_pkg::BYTES_W;
	// floor(x * RECIP / 2^SH) is exact for every BW-bit x
	localparam int SH    = BW + $clog2(DIVISOR);
	localparam int RECIP = ((1 << SH) + DIVISOR - 1) / DIVISOR;
	localparam int MW    = $clog2(RECIP + 1);
	localparam int PW    = BW + MW;

	logic          vld_s1;
	logic [BW-1:0] bytes_s1;
	logic [BW-1:0] quo_s1;
	logic          done_q;
	logic [BW-1:0] need_q;

	logic [PW-1:0] prod;
	logic [PW-1:0] back;
	logic [BW-1:0] need_raw;

	// round up when the quotient does not give the bytes back exactly
	always_comb begin
		prod     = PW'(bytes) * PW'(RECIP);
		back     = PW'(quo_s1) * PW'(DIVISOR);
		need_raw = quo_s1 + BW'(PW'(bytes_s1) != back);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			done_q   <= 1'b0;
			bytes_s1 <= '0;
			quo_s1   <= '0;
			need_q   <= BW'(1);
		end else begin
			vld_s1 <= start;
			done_q <= vld_s1;
			if (start) begin
				bytes_s1 <= bytes;
				quo_s1   <= BW'(prod >> SH);
			end
			// zero bytes still costs one block
			if (vld_s1) begin
				need_q <= (need_raw == '0) ? BW'(1) : need_raw;
			end
		end
	end

	assign done = done_q;
	assign need = need_q;

endmodule

`default_nettype wire

>>> rtl/best_fit_block_allocator.sv
// Allocate: a size division stage, one header read per cycle over the whole table,
//   then three write slots.
// Free: the same table scan and write slots, with no size stage.
// One word in flight; the next request is taken the cycle after the result loads.
// After reset the header table is cleared with ready held low.
// -----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a heap of equal blocks with coalescing on free.
// Run headers live in a single-port-write synchronous memory that is scanned
// per request, then patched with up to three header writes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "best_fit_block_allocator_defines.svh"

module best_fit_block_allocator #(
	parameter int HEAP_BLOCKS = bfba_pkg::HEAP_BLOCKS_DEF,
	parameter int BLOCK_BYTES = bfba_pkg::BLOCK_BYTES_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	bfba_req_if.sink   req,
	bfba_rsp_if.source rsp
);

	localparam int IW = $clog2(HEAP_BLOCKS);
	localparam int LW = $clog2(HEAP_BLOCKS + 1);
	localparam int DW = LW + 1;
	localparam int SW = LW + 1;
	localparam int BW = bfba_pkg::BYTES_W;
	localparam int CW = (LW > BW) ? LW : BW;

	typedef enum logic [8:0] {
		S_INIT  = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_DIV   = 9'b000000100,
		S_SCAN  = 9'b000001000,
		S_DRAIN = 9'b000010000,
		S_WR0   = 9'b000100000,
		S_WR1   = 9'b001000000,
		S_WR2   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [IW-1:0] scan_q;

	// memory ports
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [DW-1:0] wr_data;
	logic          rd_en;
	logic [DW-1:0] rd_data;
	logic          rd_vld_s1;
	logic [IW-1:0] addr_s1;

	// divider
	logic          div_start;
	logic          div_done;
	logic [BW-1:0] need;

	// request
	bfba_pkg::op_t op_q;
	logic [IW-1:0] idx_q;
	logic          oor_q;

	// scan captures
	logic          best_hit_q;
	logic [IW-1:0] best_q;
	logic [LW-1:0] best_len_q;
	logic          self_hit_q;
	logic [LW-1:0] self_len_q;
	logic          self_free_q;
	logic          next_hit_q;
	logic [IW-1:0] next_q;
	logic [LW-1:0] next_len_q;
	logic          next_free_q;
	logic          pred_hit_q;
	logic [IW-1:0] pred_q;
	logic [LW-1:0] pred_len_q;
	logic          pred_free_q;

	// output register
	logic                              out_vld_q;
	bfba_pkg::status_t                 out_status_q;
	logic [bfba_pkg::INDEX_W-1:0]      out_index_q;
	logic [bfba_pkg::BLOCKS_W-1:0]     out_blocks_q;

	logic [LW-1:0]     d_len;
	logic              d_free;
	logic              scan_last;
	logic              accept;
	logic              load;
	logic [LW-1:0]     need_l;
	logic              nmerge;
	logic              pmerge;
	logic [LW-1:0]     mlen;
	bfba_pkg::status_t free_status;
	bfba_pkg::status_t res_status;
	logic              f_ok;
	logic              a_ok;

	assign d_len     = rd_data[LW-1:0];
	assign d_free    = rd_data[LW];
	assign scan_last = (scan_q == IW'(HEAP_BLOCKS - 1));
	assign accept    = req.valid && req.ready;
	assign load      = (state_q == S_DONE) && (!out_vld_q || rsp.ready);
	assign need_l    = LW'(need);
	assign div_start = accept && (req.operation == bfba_pkg::OP_ALLOC);
	assign rd_en     = (state_q == S_SCAN);

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_status_q;
	assign rsp.granted_index  = out_index_q;
	assign rsp.granted_blocks = out_blocks_q;

	bfba_hdr_mem #(
		.DEPTH (HEAP_BLOCKS)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_q),
		.rd_data (rd_data)
	);

	bfba_size_div #(
		.DIVISOR (BLOCK_BYTES)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.bytes  (req.request_bytes),
		.done   (div_done),
		.need   (need)
	);

	// result and merge decisions
	always_comb begin
		nmerge = next_hit_q && next_free_q && (next_len_q != '0);
		pmerge = pred_hit_q && pred_free_q;
		mlen   = self_len_q + (nmerge ? next_len_q : '0);
		if (oor_q || !self_hit_q || (self_len_q == '0)) begin
			free_status = bfba_pkg::ST_NOT_START;
		end else if (self_free_q) begin
			free_status = bfba_pkg::ST_ALREADY_FREE;
		end else begin
			free_status = bfba_pkg::ST_OK;
		end
		a_ok = (op_q == bfba_pkg::OP_ALLOC) && best_hit_q;
		f_ok = (op_q == bfba_pkg::OP_FREE) && (free_status == bfba_pkg::ST_OK);
		if (op_q == bfba_pkg::OP_FREE) begin
			res_status = free_status;
		end else begin
			res_status = best_hit_q ? bfba_pkg::ST_OK : bfba_pkg::ST_NO_SPACE;
		end
	end

	// header write slots
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_INIT: begin
				wr_en   = 1'b1;
				wr_addr = scan_q;
				wr_data = (scan_q == '0) ? {1'b1, LW'(HEAP_BLOCKS)} : '0;
			end
			S_WR0: begin
				if (a_ok) begin
					wr_en   = 1'b1;
					wr_addr = best_q;
					wr_data = {1'b0, need_l};
				end else if (f_ok) begin
					wr_en   = 1'b1;
					wr_addr = pmerge ? pred_q : idx_q;
					wr_data = pmerge ? {1'b1, pred_len_q + mlen} : {1'b1, mlen};
				end
			end
			S_WR1: begin
				// split remainder, or clear the header absorbed by the predecessor
				if (a_ok && (best_len_q > need_l)) begin
					wr_en   = 1'b1;
					wr_addr = IW'(SW'(best_q) + SW'(need_l));
					wr_data = {1'b1, best_len_q - need_l};
				end else if (f_ok && pmerge) begin
					wr_en   = 1'b1;
					wr_addr = idx_q;
				end
			end
			S_WR2: begin
				if (f_ok && nmerge) begin
					wr_en   = 1'b1;
					wr_addr = next_q;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// sequencer and scan flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			scan_q     <= '0;
			rd_vld_s1  <= 1'b0;
			out_vld_q  <= 1'b0;
			best_hit_q <= 1'b0;
			self_hit_q <= 1'b0;
			next_hit_q <= 1'b0;
			pred_hit_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			if (accept) begin
				best_hit_q <= 1'b0;
				self_hit_q <= 1'b0;
				next_hit_q <= 1'b0;
				pred_hit_q <= 1'b0;
			end else if (rd_vld_s1) begin
				if ((d_len != '0) && d_free && (CW'(d_len) >= CW'(need)) &&
				    (!best_hit_q || (d_len < best_len_q))) begin
					best_hit_q <= 1'b1;
				end
				if (addr_s1 == idx_q) begin
					self_hit_q <= 1'b1;
				end
				if (self_hit_q && (SW'(addr_s1) == SW'(idx_q) + SW'(self_len_q))) begin
					next_hit_q <= 1'b1;
				end
				if ((d_len != '0) && (SW'(addr_s1) + SW'(d_len) == SW'(idx_q))) begin
					pred_hit_q <= 1'b1;
				end
			end

			unique case (state_q)
				S_INIT: begin
					scan_q <= scan_q + 1'b1;
					if (scan_last) begin
						scan_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						scan_q  <= '0;
						state_q <= (req.operation == bfba_pkg::OP_ALLOC) ? S_DIV : S_SCAN;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_last) begin
						scan_q  <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_WR0;
				S_WR0:   state_q <= S_WR1;
				S_WR1:   state_q <= S_WR2;
				S_WR2:   state_q <= S_DONE;
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	// payload captures
	always_ff @(posedge clk) begin
		addr_s1 <= scan_q;
		if (accept) begin
			op_q  <= req.operation;
			idx_q <= IW'(req.run_start);
			oor_q <= (32'(req.run_start) >= HEAP_BLOCKS);
		end
		if (rd_vld_s1) begin
			if ((d_len != '0) && d_free && (CW'(d_len) >= CW'(need)) &&
			    (!best_hit_q || (d_len < best_len_q))) begin
				best_q     <= addr_s1;
				best_len_q <= d_len;
			end
			if (addr_s1 == idx_q) begin
				self_len_q  <= d_len;
				self_free_q <= d_free;
			end
			if (self_hit_q && (SW'(addr_s1) == SW'(idx_q) + SW'(self_len_q))) begin
				next_q      <= addr_s1;
				next_len_q  <= d_len;
				next_free_q <= d_free;
			end
			if ((d_len != '0) && (SW'(addr_s1) + SW'(d_len) == SW'(idx_q))) begin
				pred_q      <= addr_s1;
				pred_len_q  <= d_len;
				pred_free_q <= d_free;
			end
		end
		if (load) begin
			out_status_q <= res_status;
			out_index_q  <= a_ok ? bfba_pkg::INDEX_W'(best_q) : '0;
			out_blocks_q <= a_ok ? bfba_pkg::BLOCKS_W'(need) : '0;
		end
	end

	`BFBA_ASSERT(a_div_done_in_div, div_done, state_q == S_DIV, "size divider finished outside DIV")
	`BFBA_ASSERT_NEXT(a_accept_starts, accept, (state_q == S_DIV) || (state_q == S_SCAN), "request did not start work")
	`BFBA_ASSERT(a_no_read_in_write, (state_q == S_WR0) || (state_q == S_WR1) || (state_q == S_WR2), !rd_vld_s1 && !rd_en, "header read overlaps write slots")
	`BFBA_ASSERT(a_grant_fits, (state_q == S_WR0) && a_ok, (CW'(best_len_q) >= CW'(need)) && (need != '0), "granted run smaller than request")

endmodule

`default_nettype wire

>>> tb/best_fit_block_allocator_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// best_fit_block_allocator_checker
// Watches the request and response channels of the allocator, keeps its own
// copy of the run-header table, predicts the reply to every accepted request
// and compares each accepted reply field by field against the oldest one due.
// -----------------------------------------------------------------------------

module best_fit_block_allocator_checker #(
	parameter int HEAP_BLOCKS = bfba_pkg::HEAP_BLOCKS_DEF,
	parameter int BLOCK_BYTES = bfba_pkg::BLOCK_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	bfba_req_if                    req,
	bfba_rsp_if                    rsp,
	output int unsigned            failures,
	output int unsigned            replies_due,
	output logic [HEAP_BLOCKS-1:0] allocated_starts
);
	import bfba_pkg::*;

	typedef struct packed {
		status_t             status;
		logic [INDEX_W-1:0]  index;
		logic [BLOCKS_W-1:0] blocks;
	} grant_t;

	logic [BLOCKS_W-1:0] seg_len  [HEAP_BLOCKS];
	bit                  seg_free [HEAP_BLOCKS];
	grant_t              grants_due [$];

	// Apply one request to the header table and return the reply it earns.
	function automatic grant_t heap_serve(op_t op, logic [BYTES_W-1:0] bytes,
			logic [START_W-1:0] start);
		grant_t reply;
		int     need;
		int     best;
		int     best_len;
		int     rest;
		int     nxt;
		bit     found;
		reply = '{status: ST_OK, index: '0, blocks: '0};
		found = 1'b0;
		best = 0;
		best_len = 0;
		if (op == OP_ALLOC) begin
			need = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
			if (need == 0)
				need = 1;
			for (int i = 0; i < HEAP_BLOCKS; i++) begin
				if (seg_len[i] != 0 && seg_free[i] && int'(seg_len[i]) >= need &&
						(!found || int'(seg_len[i]) < best_len)) begin
					found = 1'b1;
					best = i;
					best_len = seg_len[i];
				end
			end
			if (!found) begin
				reply.status = ST_NO_SPACE;
			end else begin
				if (best_len > need) begin
					rest = best + need;
					if (rest < HEAP_BLOCKS) begin
						seg_len[rest] = BLOCKS_W'(best_len - need);
						seg_free[rest] = 1'b1;
					end
					seg_len[best] = BLOCKS_W'(need);
				end
				seg_free[best] = 1'b0;
				reply.index = INDEX_W'(best);
				reply.blocks = BLOCKS_W'(need);
			end
		end else if (int'(start) >= HEAP_BLOCKS || seg_len[start] == 0) begin
			reply.status = ST_NOT_START;
		end else if (seg_free[start]) begin
			reply.status = ST_ALREADY_FREE;
		end else begin
			seg_free[start] = 1'b1;
			nxt = int'(start) + int'(seg_len[start]);
			if (nxt < HEAP_BLOCKS && seg_len[nxt] != 0 && seg_free[nxt]) begin
				seg_len[start] = seg_len[start] + seg_len[nxt];
				seg_len[nxt] = '0;
				seg_free[nxt] = 1'b0;
			end
			// only the run that ends exactly at start can absorb it
			for (int i = 0; i < int'(start); i++) begin
				if (seg_len[i] != 0 && i + int'(seg_len[i]) == int'(start)) begin
					if (seg_free[i]) begin
						seg_len[i] = seg_len[i] + seg_len[start];
						seg_len[start] = '0;
						seg_free[start] = 1'b0;
					end
					break;
				end
			end
		end
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			for (int i = 0; i < HEAP_BLOCKS; i++) begin
				seg_len[i] = '0;
				seg_free[i] = 1'b0;
			end
			seg_len[0] = BLOCKS_W'(HEAP_BLOCKS);
			seg_free[0] = 1'b1;
			grants_due.delete();
			failures = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (grants_due.size() == 0) begin
					$display("%0t: unexpected reply, status %0d index %0d blocks %0d",
						$time, rsp.status, rsp.granted_index, rsp.granted_blocks);
					failures++;
				end else begin
					want = grants_due.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
						failures++;
					end
					if (rsp.granted_index !== want.index) begin
						$display("%0t: granted_index expected %0d actual %0d",
							$time, want.index, rsp.granted_index);
						failures++;
					end
					if (rsp.granted_blocks !== want.blocks) begin
						$display("%0t: granted_blocks expected %0d actual %0d",
							$time, want.blocks, rsp.granted_blocks);
						failures++;
					end
				end
			end
			if (req.valid && req.ready)
				grants_due.push_back(heap_serve(req.operation, req.request_bytes,
					req.run_start));
		end
		replies_due = grants_due.size();
	end

	always_comb begin
		for (int i = 0; i < HEAP_BLOCKS; i++)
			allocated_starts[i] = (seg_len[i] != 0) && !seg_free[i];
	end

endmodule

>>> tb/best_fit_block_allocator_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// best_fit_block_allocator_tb
// Drives allocate and free words into the allocator: a directed walk through
// rounding, splitting, best-fit ties, merging and every error status, then
// random traffic whose frees mostly hit live runs. Both channels idle at random and
// the response side chokes once for a long stretch. The checker does the rest.
// -----------------------------------------------------------------------------

module best_fit_block_allocator_tb;
	import bfba_pkg::*;

	localparam int          HEAP         = HEAP_BLOCKS_DEF;
	localparam int          RANDOM_WORDS = 875;
	localparam int          CHOKE_AT     = 300;
	localparam int          CHOKE_CYCLES = 600;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	logic            clk;
	logic            arst_n;
	int unsigned     failures;
	int unsigned     replies_due;
	logic [HEAP-1:0] allocated_starts;
	int unsigned     words_sent;
	int unsigned     cycle_cnt;

	bfba_req_if req_ch ();
	bfba_rsp_if rsp_ch ();

	best_fit_block_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	best_fit_block_allocator_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.req              (req_ch),
		.rsp              (rsp_ch),
		.failures         (failures),
		.replies_due      (replies_due),
		.allocated_starts (allocated_starts)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// mostly short idles, now and then a long one
	function automatic int unsigned idle_span();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 16);
		return $urandom_range(30, 90);
	endfunction

	function automatic logic [START_W-1:0] pick_live(logic [HEAP-1:0] live);
		int unsigned off;
		off = $urandom_range(0, HEAP - 1);
		for (int i = 0; i < HEAP; i++) begin
			if (live[(off + i) % HEAP])
				return START_W'((off + i) % HEAP);
		end
		return START_W'(off);
	endfunction

	// call at a falling edge; returns at the rising edge that takes the word
	task automatic offer(op_t op, logic [BYTES_W-1:0] bytes, logic [START_W-1:0] start);
		req_ch.valid = 1'b1;
		req_ch.operation = op;
		req_ch.request_bytes = bytes;
		req_ch.run_start = start;
		do
			@(posedge clk);
		while (!req_ch.ready);
		words_sent++;
	endtask

	task automatic pause(int unsigned gap);
		if (gap != 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic directed_word(op_t op, int bytes, int start);
		@(negedge clk);
		offer(op, BYTES_W'(bytes), START_W'(start));
		pause(idle_span());
	endtask

	// response side: random stalls, long clean stretches, one long choke
	initial begin
		int unsigned hold_left;
		int unsigned run_left;
		bit          choke_done;
		rsp_ch.ready = 1'b0;
		hold_left = 0;
		run_left = 0;
		choke_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
			end else if (!choke_done && words_sent >= CHOKE_AT) begin
				choke_done = 1'b1;
				hold_left = CHOKE_CYCLES - 1;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = 1'b1;
				if (run_left != 0) begin
					run_left--;
				end else begin
					hold_left = idle_span();
					run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
						: $urandom_range(0, 12);
				end
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned          live;
		int unsigned          r;
		int unsigned          gap;
		int unsigned          burst_left;
		bit                   do_free;
		logic [BYTES_W-1:0]   bytes;
		logic [START_W-1:0]   start;
		arst_n = 1'b0;
		words_sent = 0;
		burst_left = 0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_ALLOC;
		req_ch.request_bytes = '0;
		req_ch.run_start = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// whole heap free: error cases first
		directed_word(OP_FREE, 0, 0);
		directed_word(OP_FREE, 0, 5);
		// rounding: zero bytes, one byte, exact block, one over a block
		directed_word(OP_ALLOC, 0, 0);
		directed_word(OP_ALLOC, 1, 0);
		directed_word(OP_ALLOC, 16, 0);
		directed_word(OP_ALLOC, 17, 0);
		// too big: a full heap while partly used, and the widest request
		directed_word(OP_ALLOC, 1024, 0);
		directed_word(OP_ALLOC, 2047, 0);
		// free with no neighbor, then merge forward, then the absorbed index
		directed_word(OP_FREE, 2047, 1);
		directed_word(OP_FREE, 0, 0);
		directed_word(OP_FREE, 0, 1);
		directed_word(OP_FREE, 0, 3);
		directed_word(OP_FREE, 0, 3);
		// merges both ways back into one run
		directed_word(OP_FREE, 0, 2);
		// exact fit of the whole heap, then nothing left
		directed_word(OP_ALLOC, 1024, 0);
		directed_word(OP_ALLOC, 1, 0);
		directed_word(OP_FREE, 0, 63);
		directed_word(OP_FREE, 0, 0);
		// holes: best fit beats the big tail, lowest index wins a tie
		directed_word(OP_ALLOC, 16, 0);
		directed_word(OP_ALLOC, 48, 0);
		directed_word(OP_ALLOC, 16, 0);
		directed_word(OP_FREE, 0, 1);
		directed_word(OP_ALLOC, 32, 0);
		directed_word(OP_FREE, 0, 0);
		directed_word(OP_ALLOC, 1, 0);

		for (int k = 0; k < RANDOM_WORDS; k++) begin
			@(negedge clk);
			live = $countones(allocated_starts);
			r = $urandom_range(0, 99);
			do_free = (live == 0) ? (r < 10) : (live > 12) ? (r < 65) : (r < 40);
			if (do_free) begin
				bytes = BYTES_W'($urandom_range(0, 2047));
				if (live != 0 && $urandom_range(0, 99) < 85)
					start = pick_live(allocated_starts);
				else
					start = START_W'($urandom_range(0, HEAP - 1));
				offer(OP_FREE, bytes, start);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					bytes = BYTES_W'($urandom_range(0, 160));
				else if (r < 92)
					bytes = BYTES_W'($urandom_range(161, 1024));
				else
					bytes = BYTES_W'($urandom_range(1025, 2047));
				offer(OP_ALLOC, bytes, START_W'($urandom_range(0, HEAP - 1)));
			end
			if (burst_left != 0) begin
				burst_left--;
				gap = 0;
			end else begin
				gap = idle_span();
				if ($urandom_range(0, 19) == 0)
					burst_left = $urandom_range(20, 40);
			end
			pause(gap);
		end

		@(negedge clk);
		req_ch.valid = 1'b0;
		while (replies_due != 0)
			@(posedge clk);
		repeat (HEAP + 40) @(posedge clk);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
